>>> hdl/fixtv_pkg.sv
// Package for the tag=value message parser: result codes, field codes,
// result record type and tag lookup helpers. No dependencies.
`default_nettype none

package fixtv_pkg;

    localparam int NUM_W = 64;          // width of the number accumulator
    localparam int QUEUE_DEPTH = 4;     // result queue entries
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DELIM_RESET = 8'd124;   // '|'
    localparam logic [7:0] CH_EQUAL = 8'd61;       // '='
    localparam logic [7:0] CH_ZERO = 8'd48;        // '0'
    localparam logic [7:0] CH_NINE = 8'd57;        // '9'
    localparam logic [7:0] CH_POINT = 8'd46;       // '.'
    localparam logic [7:0] CH_NUL = 8'd0;

    localparam logic [6:0] TAG_BAD = 7'd127;
    localparam logic [4:0] MAX_FRAC = 5'd19;

    // result kinds
    localparam logic [2:0] KIND_BEGIN = 3'd0;
    localparam logic [2:0] KIND_TEXT = 3'd1;
    localparam logic [2:0] KIND_END = 3'd2;
    localparam logic [2:0] KIND_MSGEND = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_NO_EQUAL = 2'd1;
    localparam logic [1:0] ERR_BAD_TAG = 2'd2;

    // field ids
    localparam logic [3:0] FLD_ACCOUNT = 4'd0;
    localparam logic [3:0] FLD_CLORDID = 4'd1;
    localparam logic [3:0] FLD_SEQNUM = 4'd2;
    localparam logic [3:0] FLD_QTY = 4'd3;
    localparam logic [3:0] FLD_PRICE = 4'd4;
    localparam logic [3:0] FLD_SENDER = 4'd5;
    localparam logic [3:0] FLD_SYMBOL = 4'd6;
    localparam logic [3:0] FLD_SIDE = 4'd7;
    localparam logic [3:0] FLD_TARGET = 4'd8;

    // configuration register addresses (byte address bit 2 selects the index)
    localparam logic [2:0] ADDR_DELIM = 3'd0;

    typedef enum logic [2:0] {
        PH_TAG   = 3'b001,
        PH_VALUE = 3'b010,
        PH_SKIP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  field_id;
        logic [7:0]  text_byte;
        logic [63:0] number;
        logic [4:0]  price_scale;
        logic        side_bit;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic       known;
        logic [3:0] id;
    } tag_lookup_t;

    function automatic tag_lookup_t field_of_tag(input logic [6:0] tag);
        tag_lookup_t res;
        res.known = 1'b1;
        case (tag)
            7'd1:    res.id = FLD_ACCOUNT;
            7'd11:   res.id = FLD_CLORDID;
            7'd34:   res.id = FLD_SEQNUM;
            7'd38:   res.id = FLD_QTY;
            7'd44:   res.id = FLD_PRICE;
            7'd49:   res.id = FLD_SENDER;
            7'd55:   res.id = FLD_SYMBOL;
            7'd54:   res.id = FLD_SIDE;
            7'd56:   res.id = FLD_TARGET;
            default:
            begin
                res.known = 1'b0;
                res.id = FLD_ACCOUNT;
            end
        endcase
        return res;
    endfunction

    function automatic logic is_text_field(input logic [3:0] f);
        return (f == FLD_ACCOUNT) || (f == FLD_CLORDID) || (f == FLD_SENDER) ||
               (f == FLD_SYMBOL) || (f == FLD_TARGET);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

>>> hdl/fixtv_if.sv
// Valid/ready channel interfaces: message byte input and parse result output.
// Does not depend on fixtv_pkg; payload is plain fields.
`default_nettype none

interface fixtv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;

    modport source (output valid, output msg_byte, input ready);
    modport sink (input valid, input msg_byte, output ready);
endinterface

interface fixtv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  field_id;
    logic [7:0]  text_byte;
    logic [63:0] number;
    logic [4:0]  price_scale;
    logic        side_bit;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output kind, output field_id, output text_byte,
                    output number, output price_scale, output side_bit,
                    output error_code, output last, input ready);
    modport sink (input valid, input kind, input field_id, input text_byte,
                  input number, input price_scale, input side_bit,
                  input error_code, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/fix_tag_value_parser_core.sv
// Top level of the tag=value message parser: APB register, parser, queue.
// Uses fixtv_pkg, fixtv_if, fixtv_parse and fixtv_queue.
//
//   channel   dir   beat                              handshake
//   msg_in    in    msg_byte, 0 = end of message     valid/ready
//   res_out   out   kind..last, one record per beat   valid/ready
//   apb       in    delimiter_char at 0x0             psel/penable, pready=1
//
// One byte per clock while bytes make at most one record each and res_out
// is not stalled, as msg_in.ready needs two free queue slots. Each byte is
// decoded in the cycle it is taken; its records (zero, one or two) land in
// a 4-entry queue, the first on res_out the next cycle if it was empty.
// Reset clears parser state and queue; delimiter returns to '|'.
`default_nettype none

module fix_tag_value_parser_core
    import fixtv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fixtv_in_if.sink         msg_in,
    fixtv_out_if.source      res_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] delim_reg;
    logic       room;
    logic       accept;
    logic       not_empty;
    push_t      push;
    result_t    head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_DELIM[2]) ? {24'd0, delim_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == ADDR_DELIM[2])
        begin
            delim_reg <= pwdata[7:0];
        end
    end

    assign msg_in.ready = room;
    assign accept = msg_in.valid && room;

    fixtv_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .msg_byte (msg_in.msg_byte),
        .delim    (delim_reg),
        .push     (push)
    );

    fixtv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (not_empty && res_out.ready),
        .room      (room),
        .not_empty (not_empty),
        .head      (head)
    );

    assign res_out.valid = not_empty;
    assign res_out.kind = head.kind;
    assign res_out.field_id = head.field_id;
    assign res_out.text_byte = head.text_byte;
    assign res_out.number = head.number;
    assign res_out.price_scale = head.price_scale;
    assign res_out.side_bit = head.side_bit;
    assign res_out.error_code = head.error_code;
    assign res_out.last = head.last;

endmodule

`default_nettype wire

>>> hdl/fixtv_parse.sv
// Parser state and per-byte decode: tag accumulation, value conversion and
// generation of up to two result records per byte. Uses fixtv_pkg.
`default_nettype none

module fixtv_parse
    import fixtv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] msg_byte,
    input  wire logic [7:0] delim,
    output push_t           push
);

    phase_t             phase_reg, phase_next;
    logic [6:0]         tag_reg, tag_next;
    logic               nonempty_reg, nonempty_next;
    logic [3:0]         field_reg, field_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [4:0]         frac_reg, frac_next;
    logic               point_reg, point_next;
    logic               stopped_reg, stopped_next;
    logic               zero_text_reg, zero_text_next;
    logic [1:0]         vlen_reg, vlen_next;

    logic               clear;
    logic [10:0]        tag_prod;
    logic [NUM_W+3:0]   num_prod;
    logic [3:0]         digit;
    tag_lookup_t        lookup;
    result_t            fe;
    result_t            r0, r1;
    logic [1:0]         n;

    assign digit = 4'(msg_byte - CH_ZERO);
    assign tag_prod = 11'(tag_reg) * 11'd10 + 11'(digit);
    // acc*10 + d; any bit above NUM_W means the value would overflow
    assign num_prod = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                      (NUM_W+4)'(digit);
    assign lookup = field_of_tag(tag_reg);

    // field end record for the current field
    always_comb
    begin
        fe = '0;
        fe.kind = KIND_END;
        fe.field_id = field_reg;
        case (field_reg)
            FLD_SEQNUM:  fe.number = 64'(acc_reg);
            FLD_QTY:     fe.number = {32'd0, acc_reg[31:0]};
            FLD_PRICE:
            begin
                fe.number = 64'(acc_reg);
                fe.price_scale = frac_reg;
            end
            FLD_SIDE:    fe.side_bit = !(zero_text_reg && vlen_reg == 2'd1);
            default:     fe.number = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        tag_next = tag_reg;
        nonempty_next = nonempty_reg;
        field_next = field_reg;
        acc_next = acc_reg;
        frac_next = frac_reg;
        point_next = point_reg;
        stopped_next = stopped_reg;
        zero_text_next = zero_text_reg;
        vlen_next = vlen_reg;
        clear = 1'b0;
        n = 2'd0;
        r0 = '0;
        r1 = '0;

        if (msg_byte == CH_NUL)
        begin
            r1.kind = KIND_MSGEND;
            r0 = r1;
            if (phase_reg == PH_VALUE)
            begin
                r0 = fe;
                n = 2'd2;
            end
            else if (phase_reg == PH_TAG && nonempty_reg)
            begin
                r0 = '0;
                r0.kind = KIND_ERROR;
                r0.error_code = ERR_NO_EQUAL;
                n = 2'd2;
            end
            else
            begin
                n = 2'd1;
            end
            phase_next = PH_TAG;
            clear = 1'b1;
        end
        else if (phase_reg == PH_SKIP)
        begin
            n = 2'd0;
        end
        else if (msg_byte == delim)
        begin
            n = 2'd1;
            if (phase_reg == PH_VALUE)
            begin
                r0 = fe;
                phase_next = PH_TAG;
            end
            else
            begin
                r0.kind = KIND_ERROR;
                r0.error_code = ERR_NO_EQUAL;
                phase_next = PH_SKIP;
            end
            clear = 1'b1;
        end
        else if (phase_reg == PH_TAG)
        begin
            if (msg_byte == CH_EQUAL)
            begin
                n = 2'd1;
                clear = 1'b1;
                if (nonempty_reg && lookup.known)
                begin
                    r0.kind = KIND_BEGIN;
                    r0.field_id = lookup.id;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    r0.kind = KIND_ERROR;
                    r0.error_code = ERR_BAD_TAG;
                    phase_next = PH_SKIP;
                end
            end
            else
            begin
                nonempty_next = 1'b1;
                if (is_digit(msg_byte) && tag_reg != TAG_BAD)
                begin
                    tag_next = (tag_prod > 11'd126) ? TAG_BAD : tag_prod[6:0];
                end
                else
                begin
                    tag_next = TAG_BAD;
                end
            end
        end
        else if (is_text_field(field_reg))
        begin
            n = 2'd1;
            r0.kind = KIND_TEXT;
            r0.field_id = field_reg;
            r0.text_byte = msg_byte;
        end
        else if (field_reg == FLD_SIDE)
        begin
            if (vlen_reg == 2'd0)
            begin
                zero_text_next = (msg_byte == CH_ZERO);
            end
            if (vlen_reg != 2'd2)
            begin
                vlen_next = vlen_reg + 2'd1;
            end
        end
        else if (!stopped_reg)
        begin
            if (is_digit(msg_byte))
            begin
                if (point_reg && frac_reg >= MAX_FRAC)
                begin
                    stopped_next = 1'b1;
                end
                else if (num_prod[NUM_W+3:NUM_W] != 4'd0)
                begin
                    // saturate only before the point; fraction digit is dropped
                    if (!point_reg)
                    begin
                        acc_next = '1;
                    end
                    stopped_next = 1'b1;
                end
                else
                begin
                    acc_next = num_prod[NUM_W-1:0];
                    if (point_reg)
                    begin
                        frac_next = frac_reg + 5'd1;
                    end
                end
            end
            else if (msg_byte == CH_POINT && field_reg == FLD_PRICE && !point_reg)
            begin
                point_next = 1'b1;
            end
            else
            begin
                stopped_next = 1'b1;
            end
        end

        if (clear)
        begin
            tag_next = '0;
            nonempty_next = 1'b0;
            field_next = (phase_next == PH_VALUE) ? r0.field_id : FLD_ACCOUNT;
            acc_next = '0;
            frac_next = '0;
            point_next = 1'b0;
            stopped_next = 1'b0;
            zero_text_next = 1'b0;
            vlen_next = '0;
        end

        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        r1.last = 1'b1;
    end

    assign push = {(accept ? n : 2'd0), r0, r1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg <= '0;
            nonempty_reg <= 1'b0;
            field_reg <= '0;
            acc_reg <= '0;
            frac_reg <= '0;
            point_reg <= 1'b0;
            stopped_reg <= 1'b0;
            zero_text_reg <= 1'b0;
            vlen_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tag_reg <= tag_next;
            nonempty_reg <= nonempty_next;
            field_reg <= field_next;
            acc_reg <= acc_next;
            frac_reg <= frac_next;
            point_reg <= point_next;
            stopped_reg <= stopped_next;
            zero_text_reg <= zero_text_next;
            vlen_reg <= vlen_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fixtv_queue.sv
// Result queue: takes up to two records per cycle, hands out one per beat.
// Uses fixtv_pkg (push_t, result_t, depth constants).
`default_nettype none

module fixtv_queue
    import fixtv_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire push_t  push,
    input  wire logic   pop,
    output logic        room,
    output logic        not_empty,
    output result_t     head
);

    result_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next;
    logic [QPTR_W-1:0]  rd_reg, rd_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic [QPTR_W-1:0]  wr_second;

    // two free slots needed, since one byte can make two records
    assign room = cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign not_empty = cnt_reg != '0;
    assign head = entry_reg[rd_reg];
    assign wr_second = wr_reg + QPTR_W'(1);

    assign wr_next = wr_reg + QPTR_W'(push.count);
    assign rd_next = pop ? rd_reg + QPTR_W'(1) : rd_reg;
    assign cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_second] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fixtv_chk.sv
// Port-level checker for the tag=value parser, bound to the top level.
// Uses fixtv_pkg result codes.
`default_nettype none

module fixtv_chk
    import fixtv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_kind,
    input wire logic [3:0]  out_field_id,
    input wire logic [63:0] out_number,
    input wire logic [1:0]  out_error_code,
    input wire logic        out_last
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("result beat changed while stalled");

    // message end is always the final record of its byte
    a_msgend_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_MSGEND |-> out_last)
        else $error("message end without last");

    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_ERROR |->
            out_error_code != ERR_NONE && out_field_id == FLD_ACCOUNT)
        else $error("malformed error record");

    // field begin is the only record of its byte and carries no number
    a_begin_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_BEGIN |-> out_last && out_number == 64'd0)
        else $error("malformed field begin record");

endmodule

bind fix_tag_value_parser_core fixtv_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (res_out.valid),
    .out_ready      (res_out.ready),
    .out_kind       (res_out.kind),
    .out_field_id   (res_out.field_id),
    .out_number     (res_out.number),
    .out_error_code (res_out.error_code),
    .out_last       (res_out.last)
);

`default_nettype wire

>>> tb/sv/tb_fix_tag_value_parser_core.sv
// Self-checking testbench for fix_tag_value_parser_core: message bytes in,
// parse records out, checked against an in-bench model of the parser.
// Depends on fixtv_pkg, fixtv_if and the parser core RTL.

module tb_fix_tag_value_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import fixtv_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;
    localparam logic [63:0] NUM_MAX = '1;
    localparam logic [3:0] NO_FIELD = 4'd0;

    typedef struct {
        logic [7:0] b;
        int         n;      // -1: results come from the model
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fixtv_in_if  msg_ch();
    fixtv_out_if res_ch();

    fix_tag_value_parser_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_ch),
        .res_out (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser model state
    logic [7:0]  delim;
    phase_t      ph;
    logic [6:0]  tag_acc;
    logic        tok_ne;
    logic [3:0]  fld;
    logic [63:0] acc;
    logic [4:0]  frac;
    logic        pt;
    logic        stopped;
    logic        zero_txt;
    logic [1:0]  vlen;

    stim_row_t   directed_rows[$];
    result_t     pending_results[$];
    result_t     byte_results[$];
    logic [7:0]  msg_bytes[$];
    int          known_tags[9] = '{1, 11, 34, 38, 44, 49, 55, 54, 56};
    logic [7:0]  phase_delims[6];

    int errors = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int useful_items = 0;
    bit no_gaps = 1'b0;

    function automatic result_t rec(input logic [2:0] k, input logic [3:0] f,
                                    input logic [7:0] t, input logic [63:0] num,
                                    input logic [4:0] sc, input logic sd,
                                    input logic [1:0] e, input logic l);
        result_t r;
        r.kind = k;
        r.field_id = f;
        r.text_byte = t;
        r.number = num;
        r.price_scale = sc;
        r.side_bit = sd;
        r.error_code = e;
        r.last = l;
        return r;
    endfunction

    // {known, field id}
    function automatic logic [4:0] tag_field(input logic [6:0] t);
        case (t)
            7'd1:    return {1'b1, FLD_ACCOUNT};
            7'd11:   return {1'b1, FLD_CLORDID};
            7'd34:   return {1'b1, FLD_SEQNUM};
            7'd38:   return {1'b1, FLD_QTY};
            7'd44:   return {1'b1, FLD_PRICE};
            7'd49:   return {1'b1, FLD_SENDER};
            7'd55:   return {1'b1, FLD_SYMBOL};
            7'd54:   return {1'b1, FLD_SIDE};
            7'd56:   return {1'b1, FLD_TARGET};
            default: return 5'd0;
        endcase
    endfunction

    function automatic bit text_field(input logic [3:0] f);
        return f == FLD_ACCOUNT || f == FLD_CLORDID || f == FLD_SENDER ||
               f == FLD_SYMBOL || f == FLD_TARGET;
    endfunction

    task automatic start_token();
        tag_acc = '0;
        tok_ne = 1'b0;
        fld = NO_FIELD;
        acc = '0;
        frac = '0;
        pt = 1'b0;
        stopped = 1'b0;
        zero_txt = 1'b0;
        vlen = '0;
    endtask

    function automatic result_t field_end_rec();
        logic [63:0] num;
        logic [4:0]  sc;
        logic        sd;
        num = '0;
        sc = '0;
        sd = 1'b0;
        case (fld)
            FLD_SEQNUM: num = acc;
            FLD_QTY:    num = {32'd0, acc[31:0]};
            FLD_PRICE:
            begin
                num = acc;
                sc = frac;
            end
            FLD_SIDE:   sd = !(zero_txt && vlen == 2'd1);
            default:    ;
        endcase
        return rec(KIND_END, fld, 8'd0, num, sc, sd, ERR_NONE, 1'b0);
    endfunction

    task automatic take_number_byte(input logic [7:0] b);
        logic [63:0] d;
        d = {56'd0, b - CH_ZERO};
        if (stopped)
        begin
            // rest of the value is ignored
        end
        else if (b >= CH_ZERO && b <= CH_NINE)
        begin
            if (pt && frac >= MAX_FRAC)
                stopped = 1'b1;
            else if (acc > (NUM_MAX - d) / 64'd10)
            begin
                // integer part saturates; a fraction digit is just dropped
                if (!pt)
                    acc = NUM_MAX;
                stopped = 1'b1;
            end
            else
            begin
                acc = acc * 64'd10 + d;
                if (pt)
                    frac = frac + 5'd1;
            end
        end
        else if (b == CH_POINT && fld == FLD_PRICE && !pt)
            pt = 1'b1;
        else
            stopped = 1'b1;
    endtask

    // Records caused by one byte, left in byte_results.
    task automatic decode_byte(input logic [7:0] b);
        logic [4:0] tf;
        int         t;
        byte_results.delete();
        if (b == CH_NUL)
        begin
            if (ph == PH_VALUE)
                byte_results.push_back(field_end_rec());
            else if (ph == PH_TAG && tok_ne)
                byte_results.push_back(rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                           ERR_NO_EQUAL, 1'b0));
            byte_results.push_back(rec(KIND_MSGEND, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                       ERR_NONE, 1'b0));
            ph = PH_TAG;
            start_token();
        end
        else if (ph == PH_SKIP)
        begin
            // dropped until the end byte
        end
        else if (b == delim)
        begin
            if (ph == PH_VALUE)
            begin
                byte_results.push_back(field_end_rec());
                ph = PH_TAG;
            end
            else
            begin
                byte_results.push_back(rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                           ERR_NO_EQUAL, 1'b0));
                ph = PH_SKIP;
            end
            start_token();
        end
        else if (ph == PH_TAG)
        begin
            if (b == CH_EQUAL)
            begin
                tf = tok_ne ? tag_field(tag_acc) : 5'd0;
                start_token();
                if (!tf[4])
                begin
                    byte_results.push_back(rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                               ERR_BAD_TAG, 1'b0));
                    ph = PH_SKIP;
                end
                else
                begin
                    fld = tf[3:0];
                    byte_results.push_back(rec(KIND_BEGIN, fld, 8'd0, '0, '0, 1'b0,
                                               ERR_NONE, 1'b0));
                    ph = PH_VALUE;
                end
            end
            else
            begin
                tok_ne = 1'b1;
                if (b >= CH_ZERO && b <= CH_NINE && tag_acc != TAG_BAD)
                begin
                    t = int'(tag_acc) * 10 + int'(b - CH_ZERO);
                    tag_acc = (t > 126) ? TAG_BAD : t[6:0];
                end
                else
                    tag_acc = TAG_BAD;
            end
        end
        else if (text_field(fld))
            byte_results.push_back(rec(KIND_TEXT, fld, b, '0, '0, 1'b0, ERR_NONE, 1'b0));
        else if (fld == FLD_SIDE)
        begin
            if (vlen == 2'd0)
                zero_txt = (b == CH_ZERO);
            if (vlen < 2'd2)
                vlen = vlen + 2'd1;
        end
        else
            take_number_byte(b);
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Drive one byte, wait for its beat, then queue what it should cause.
    task automatic feed(input logic [7:0] b, input int n, input result_t r0,
                        input result_t r1);
        int gap;
        bit counted;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.msg_byte <= b;
        do @(posedge clk); while (!msg_ch.ready);
        counted = (ph != PH_SKIP) || (b == CH_NUL);
        decode_byte(b);
        if (n < 0)
        begin
            foreach (byte_results[i])
                pending_results.push_back(byte_results[i]);
        end
        else
        begin
            if (n > 0)
                pending_results.push_back(r0);
            if (n > 1)
                pending_results.push_back(r1);
        end
        if (counted)
            useful_items++;
    endtask

    task automatic add_row(input logic [7:0] b, input int n, input result_t r0,
                           input result_t r1);
        stim_row_t row;
        row.b = b;
        row.n = n;
        row.r0 = r0;
        row.r1 = r1;
        directed_rows.push_back(row);
    endtask

    task automatic wait_drained();
        msg_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // bytes in skip make no record but may still be in flight
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_delimiter(input logic [7:0] v);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, ADDR_DELIM, {24'd0, v}, rd);
        delim = v;
        apb_access(1'b0, ADDR_DELIM, 32'd0, rd);
        check_field("delimiter readback", {56'd0, v}, {32'd0, rd});
    endtask

    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(32, 126)) :
                                               8'($urandom_range(1, 255));
        while (b == CH_NUL || b == delim);
        return b;
    endfunction

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_bytes.push_back(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) msg_bytes.push_back(8'($urandom_range(CH_NINE, CH_ZERO)));
    endtask

    function automatic int num_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        if (r < 90)
            return $urandom_range(7, 18);
        return $urandom_range(19, 24);
    endfunction

    task automatic gen_value(input logic [3:0] f);
        int r;
        r = $urandom_range(0, 99);
        if (text_field(f))
            repeat ($urandom_range(0, 8)) msg_bytes.push_back(value_byte());
        else if (f == FLD_SIDE)
        begin
            case ($urandom_range(0, 5))
                0: push_str("0");
                1: push_str("1");
                2: push_str("00");
                3: ;
                4:
                begin
                    push_str("0");
                    msg_bytes.push_back(value_byte());
                end
                default: repeat ($urandom_range(1, 3)) msg_bytes.push_back(value_byte());
            endcase
        end
        else
        begin
            if (r < 4)
                push_str($sformatf("%0d", NUM_MAX));
            else if (r < 7)
                push_str("18446744073709551616");
            else
                push_digits(num_len());
            if (f == FLD_PRICE && $urandom_range(0, 9) < 7)
            begin
                msg_bytes.push_back(CH_POINT);
                push_digits(num_len());
            end
            if ($urandom_range(0, 9) == 0)
            begin
                msg_bytes.push_back(value_byte());
                push_digits($urandom_range(0, 3));
            end
        end
    endtask

    // Mostly well-formed messages; some noise, empty tokens and bad tags.
    task automatic gen_message();
        int         nf;
        int         s;
        int         tag;
        logic [4:0] tf;
        msg_bytes.delete();
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 15)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        else
        begin
            nf = $urandom_range(1, 6);
            for (int i = 0; i < nf; i++)
            begin
                s = $urandom_range(0, 99);
                if (s < 5)
                    push_digits($urandom_range(0, 3));
                else if (s < 11)
                begin
                    case ($urandom_range(0, 2))
                        0: push_str($sformatf("%0d", $urandom_range(0, 999)));
                        1:
                        begin
                            push_digits($urandom_range(0, 2));
                            msg_bytes.push_back(value_byte());
                        end
                        default: ;
                    endcase
                    msg_bytes.push_back(CH_EQUAL);
                    push_digits($urandom_range(0, 3));
                end
                else
                begin
                    tag = known_tags[$urandom_range(0, 8)];
                    if ($urandom_range(0, 9) == 0)
                        msg_bytes.push_back(CH_ZERO);
                    push_str($sformatf("%0d", tag));
                    msg_bytes.push_back(CH_EQUAL);
                    tf = tag_field(tag[6:0]);
                    gen_value(tf[3:0]);
                end
                if (i < nf - 1 || $urandom_range(0, 3) != 0)
                    msg_bytes.push_back(delim);
            end
        end
        msg_bytes.push_back(CH_NUL);
    endtask

    // result sink: random stalls, plus one long hold to back up the queue
    initial
    begin
        int stall;
        int run;
        bit held;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = rec(res_ch.kind, res_ch.field_id, res_ch.text_byte, res_ch.number,
                      res_ch.price_scale, res_ch.side_bit, res_ch.error_code, res_ch.last);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat: expected none, got kind %0d field %0d",
                             $time, got.kind, got.field_id);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(got.kind));
                check_field("field_id", 64'(want.field_id), 64'(got.field_id));
                check_field("text_byte", 64'(want.text_byte), 64'(got.text_byte));
                check_field("number", want.number, got.number);
                check_field("price_scale", 64'(want.price_scale), 64'(got.price_scale));
                check_field("side_bit", 64'(want.side_bit), 64'(got.side_bit));
                check_field("error_code", 64'(want.error_code), 64'(got.error_code));
                check_field("last", 64'(want.last), 64'(got.last));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        result_t none;
        result_t msg_end;
        none = '0;
        msg_end = rec(KIND_MSGEND, NO_FIELD, 8'd0, '0, '0, 1'b0, ERR_NONE, 1'b1);
        phase_delims[0] = DELIM_RESET;
        phase_delims[1] = 8'h01;
        phase_delims[2] = CH_NUL;      // never matches
        phase_delims[3] = 8'hFF;
        phase_delims[4] = CH_EQUAL;    // wins over '=' as tag end
        phase_delims[5] = 8'h3B;

        rst_n <= 1'b0;
        msg_ch.valid <= 1'b0;
        msg_ch.msg_byte <= 8'd0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_DELIM;
        pwdata <= 32'd0;
        delim = DELIM_RESET;
        ph = PH_TAG;
        start_token();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, empty token, skip until end
        add_row(CH_NUL, 1, msg_end, none);
        add_row(DELIM_RESET, 1, rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                    ERR_NO_EQUAL, 1'b1), none);
        add_row("x", 0, none, none);
        add_row(CH_NUL, 1, msg_end, none);
        // side "0", closed by the end byte
        add_row("5", 0, none, none);
        add_row("4", 0, none, none);
        add_row(CH_EQUAL, 1, rec(KIND_BEGIN, FLD_SIDE, 8'd0, '0, '0, 1'b0, ERR_NONE, 1'b1),
                none);
        add_row(CH_ZERO, 0, none, none);
        add_row(CH_NUL, 2, rec(KIND_END, FLD_SIDE, 8'd0, '0, '0, 1'b0, ERR_NONE, 1'b0),
                msg_end);
        // empty tag
        add_row(CH_EQUAL, 1, rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0,
                                 ERR_BAD_TAG, 1'b1), none);
        add_row("A", 0, none, none);
        add_row(CH_NUL, 1, msg_end, none);
        // text field with the top byte value
        add_row("1", 0, none, none);
        add_row(CH_EQUAL, 1, rec(KIND_BEGIN, FLD_ACCOUNT, 8'd0, '0, '0, 1'b0, ERR_NONE, 1'b1),
                none);
        add_row(8'hFF, 1, rec(KIND_TEXT, FLD_ACCOUNT, 8'hFF, '0, '0, 1'b0, ERR_NONE, 1'b1),
                none);
        add_row(DELIM_RESET, 1, rec(KIND_END, FLD_ACCOUNT, 8'd0, '0, '0, 1'b0,
                                    ERR_NONE, 1'b1), none);
        // end byte inside a tag
        add_row("7", 0, none, none);
        add_row(CH_NUL, 2, rec(KIND_ERROR, NO_FIELD, 8'd0, '0, '0, 1'b0, ERR_NO_EQUAL, 1'b0),
                msg_end);
        // short price with a fraction
        add_row("4", -1, none, none);
        add_row("4", -1, none, none);
        add_row(CH_EQUAL, -1, none, none);
        add_row(CH_POINT, -1, none, none);
        add_row("5", -1, none, none);
        add_row(CH_NUL, -1, none, none);

        foreach (directed_rows[i])
            feed(directed_rows[i].b, directed_rows[i].n, directed_rows[i].r0,
                 directed_rows[i].r1);

        foreach (phase_delims[p])
        begin
            set_delimiter(phase_delims[p]);
            useful_items = 0;
            while (useful_items < ITEMS_PER_PHASE)
            begin
                gen_message();
                no_gaps = ($urandom_range(0, 4) == 0);
                foreach (msg_bytes[i])
                    feed(msg_bytes[i], -1, none, none);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
